// ===== rtl/sukt_pkg.sv =====
// ----------------------------------------------------------------------------
// sukt_pkg
// Shared types and codes for the sorted unique key table.
// ----------------------------------------------------------------------------
package sukt_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 5;
  // status, key_out and occupancy packed from the lowest bit up, 40 bits
  localparam int unsigned OUT_W    = STATUS_W + KEY_W + OCC_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_LIST   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_DUP      = 3'd1,
    STATUS_NOTFOUND = 3'd2,
    STATUS_FULL     = 3'd3,
    STATUS_EMPTY    = 3'd4
  } status_e;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_e;

  typedef struct packed {
    op_e                    op;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

  // What a cell shows its neighbours
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    lt;     // holds a key below the broadcast key
    logic                    valid;
  } cell_link_t;

endpackage

// ===== rtl/sorted_unique_key_table.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_key_table
// Ordered set of signed 32-bit keys kept in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel: tuser carries the operation
//   (insert, delete, search, list) and tdata the signed key. Results leave on
//   the m_axis channel: tdata packs status, key_out and occupancy, tlast marks
//   the final result of an item.
//   Every cell compares its key with the broadcast key in the same cycle, so
//   insert, delete and search finish in the cycle of acceptance and give one
//   result in the output register on the next cycle: one item per cycle while
//   the receiver keeps taking results.
//   A list on a non-empty table enters its list state, then emits one stored
//   key per cycle while results are taken: the chain rotates left by one cell
//   per emitted key and cell 0 is emitted, so after the last key the table
//   stands in its original order again. No item is accepted during a list.
//   Reset clears the occupancy, every cell's valid bit and the output valid;
//   the stored keys themselves are not cleared.
//   When the receiver stalls, hold the result in the output register and stop
//   accepting items (or stop rotating) until it is taken.
// ----------------------------------------------------------------------------
module sorted_unique_key_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sukt_pkg::KEY_W-1:0]       s_axis_tdata,   // [31:0] key
  input  logic [sukt_pkg::MODE_W-1:0]      s_axis_tuser,   // [1:0] mode
  // result out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sukt_pkg::OUT_W-1:0]       m_axis_tdata,   // [2:0] status,
                                                           // [34:3] key_out,
                                                           // [39:35] occupancy
  output logic                             m_axis_tlast
);
  import sukt_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    o_valid_q, o_valid_d;
  status_e                 o_status_q, o_status_d;
  logic signed [KEY_W-1:0] o_key_q, o_key_d;
  logic [CNT_W-1:0]        o_occ_q, o_occ_d;
  logic                    o_last_q, o_last_d;

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  cell_ctrl_t              ctrl;
  cell_link_t              links [CAPACITY];
  logic [CAPACITY-1:0]     eq;
  cell_link_t              left_edge, right_edge;

  // Virtual cell left of cell 0 always ranks below the key and is occupied
  assign left_edge  = '{key: '0, lt: 1'b1, valid: 1'b1};
  assign right_edge = '{key: '0, lt: 1'b0, valid: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sukt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .left_i     ((i == 0) ? left_edge : links[(i == 0) ? 0 : i - 1]),
      .right_i    ((i == CAPACITY - 1) ? right_edge
                                       : links[(i == CAPACITY - 1) ? i : i + 1]),
      .wrap_key_i (links[0].key),
      .link_o     (links[i]),
      .eq_o       (eq[i])
    );
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  logic  out_free;
  logic  accept;
  logic  found;
  logic  empty;
  logic  full;
  logic  list_last;
  mode_e mode;

  assign out_free  = !o_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign found     = |eq;
  assign empty     = (count_q == '0);
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign list_last = (CNT_W'(idx_q) == count_q - CNT_W'(1));
  assign mode      = mode_e'(s_axis_tuser);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && mode == MODE_LIST && !empty) begin
          state_d = ST_LIST;
        end
      end
      ST_LIST: begin
        if (out_free && list_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: cell operation, result register, counters
  always_comb begin
    ctrl       = '{op: OP_HOLD, key: signed'(s_axis_tdata)};
    count_d    = count_q;
    idx_d      = idx_q;
    o_valid_d  = o_valid_q && !m_axis_tready;
    o_status_d = o_status_q;
    o_key_d    = o_key_q;
    o_occ_d    = o_occ_q;
    o_last_d   = o_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          o_valid_d  = 1'b1;
          o_status_d = STATUS_OK;
          o_key_d    = '0;
          o_last_d   = 1'b1;
          idx_d      = '0;
          case (mode)
            MODE_INSERT: begin
              if (found) begin
                o_status_d = STATUS_DUP;
              end else if (full) begin
                o_status_d = STATUS_FULL;
              end else begin
                ctrl.op = OP_INSERT;
                count_d = count_q + CNT_W'(1);
              end
            end
            MODE_DELETE, MODE_SEARCH: begin
              if (empty) begin
                o_status_d = STATUS_EMPTY;
              end else if (!found) begin
                o_status_d = STATUS_NOTFOUND;
              end else if (mode == MODE_DELETE) begin
                ctrl.op = OP_DELETE;
                count_d = count_q - CNT_W'(1);
              end else begin
                o_key_d = signed'(s_axis_tdata);
              end
            end
            default: begin
              // List: report empty now, else enter the list state, which emits the keys
              if (empty) begin
                o_status_d = STATUS_EMPTY;
              end else begin
                o_valid_d = o_valid_q && !m_axis_tready;
              end
            end
          endcase
          o_occ_d = count_d;
        end
      end
      ST_LIST: begin
        if (out_free) begin
          ctrl.op    = OP_ROTATE;
          o_valid_d  = 1'b1;
          o_status_d = STATUS_OK;
          o_key_d    = links[0].key;
          o_occ_d    = count_q;
          o_last_d   = list_last;
          idx_d      = idx_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      o_valid_q <= o_valid_d;
    end
  end

  // Result payload: no reset needed
  always_ff @(posedge clk_i) begin
    o_status_q <= o_status_d;
    o_key_q    <= o_key_d;
    o_occ_q    <= o_occ_d;
    o_last_q   <= o_last_d;
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {OCC_W'(o_occ_q), o_key_q, o_status_q};
  assign m_axis_tlast  = o_last_q;

endmodule

// ===== rtl/sukt_cell.sv =====
// ----------------------------------------------------------------------------
// sukt_cell
// One slot of the sorted chain: holds a key, compares it with the broadcast
// key and shifts left or right with its neighbours.
// ----------------------------------------------------------------------------
module sukt_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sukt_pkg::cell_ctrl_t                ctrl_i,
  input  sukt_pkg::cell_link_t                left_i,
  input  sukt_pkg::cell_link_t                right_i,
  input  logic signed [sukt_pkg::KEY_W-1:0]   wrap_key_i,
  output sukt_pkg::cell_link_t                link_o,
  output logic                                eq_o
);
  import sukt_pkg::*;

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    valid_q, valid_d;
  logic                    lt;

  assign lt     = valid_q && (key_q < ctrl_i.key);
  assign eq_o   = valid_q && (key_q == ctrl_i.key);
  assign link_o = '{key: key_q, lt: lt, valid: valid_q};

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        // Keep smaller keys; first cell not below takes the key, rest shift right
        if (!lt) begin
          key_d = left_i.lt ? ctrl_i.key : left_i.key;
        end
        valid_d = valid_q || left_i.valid;
      end
      OP_DELETE: begin
        // Close the gap from the matching slot upwards
        if (!lt) begin
          key_d = right_i.key;
        end
        valid_d = right_i.valid;
      end
      OP_ROTATE: begin
        if (right_i.valid) begin
          key_d = right_i.key;
        end else if (valid_q) begin
          key_d = wrap_key_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// ===== rtl/sukt_checker.sv =====
// ----------------------------------------------------------------------------
// sukt_port_checks
// Port-level checks for the sorted unique key table, bound to the top level.
// ----------------------------------------------------------------------------
module sukt_port_checks #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [sukt_pkg::OUT_W-1:0]   m_axis_tdata,
  input logic                         m_axis_tlast
);
  import sukt_pkg::*;

  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occ;

  assign status = m_axis_tdata[STATUS_W-1:0];
  assign occ    = m_axis_tdata[OUT_W-1 -: OCC_W];

  // Insert, delete and search give one final result each, so a non-final result belongs to a list and must be ok
  a_nonlast_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> status == STATUS_OK)
    else $error("non-final result with error status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> status <= STATUS_EMPTY)
    else $error("status code out of range");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (CAPACITY < 32) |-> occ <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_list_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("item accepted in the middle of a list");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind sorted_unique_key_table sukt_port_checks #(.CAPACITY(CAPACITY)) u_sukt_checker (.*);

// ===== verif/sukt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sukt_checker
// Watches both stream channels of the key table, keeps its own sorted copy of
// the stored keys, predicts every result and compares it with what leaves.
// ----------------------------------------------------------------------------
module sukt_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  input  logic                        s_axis_tready_i,
  input  logic [sukt_pkg::KEY_W-1:0]  s_axis_tdata_i,   // [31:0] key
  input  logic [sukt_pkg::MODE_W-1:0] s_axis_tuser_i,   // [1:0] mode
  input  logic                        m_axis_tvalid_i,
  input  logic                        m_axis_tready_i,
  input  logic [sukt_pkg::OUT_W-1:0]  m_axis_tdata_i,   // [2:0] status,
                                                        // [34:3] key_out,
                                                        // [39:35] occupancy
  input  logic                        m_axis_tlast_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 results_o,
  output logic [4:0]                  status_seen_o
);
  import sukt_pkg::*;

  typedef struct packed {
    status_e                 status;
    logic signed [KEY_W-1:0] key;
    logic [OCC_W-1:0]        occ;
    logic                    last;
  } result_t;

  logic signed [KEY_W-1:0] sorted_keys [CAPACITY];
  int unsigned             key_count   = 0;
  result_t                 due_results [$];
  result_t                 got;
  result_t                 want;
  int unsigned             n_fail      = 0;
  int unsigned             n_results   = 0;
  int unsigned             n_due       = 0;
  logic [4:0]              seen        = '0;

  assign fail_count_o  = n_fail;
  assign pending_o     = n_due;
  assign results_o     = n_results;
  assign status_seen_o = seen;

  function automatic void note_failure(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("%t  %s", $realtime, msg);
  endfunction

  // Occupancy is taken after the operation has changed the table
  function automatic void push_result(input status_e st, input logic signed [KEY_W-1:0] k,
                                      input logic lst);
    result_t r;
    r.status = st;
    r.key    = k;
    r.occ    = OCC_W'(key_count);
    r.last   = lst;
    due_results.push_back(r);
  endfunction

  task automatic apply_table_op(input mode_e mode, input logic signed [KEY_W-1:0] key);
    int unsigned pos;
    int unsigned i;
    pos = 0;
    while (pos < key_count && sorted_keys[pos] < key) pos++;
    if (mode == MODE_INSERT) begin
      // a duplicate wins over a full table
      if (pos < key_count && sorted_keys[pos] == key) begin
        push_result(STATUS_DUP, '0, 1'b1);
      end else if (key_count >= CAPACITY) begin
        push_result(STATUS_FULL, '0, 1'b1);
      end else begin
        for (i = key_count; i > pos; i--) sorted_keys[i] = sorted_keys[i-1];
        sorted_keys[pos] = key;
        key_count++;
        push_result(STATUS_OK, '0, 1'b1);
      end
    end else if (key_count == 0) begin
      push_result(STATUS_EMPTY, '0, 1'b1);
    end else if (mode == MODE_LIST) begin
      for (i = 0; i < key_count; i++) push_result(STATUS_OK, sorted_keys[i], i + 1 == key_count);
    end else if (pos >= key_count || sorted_keys[pos] != key) begin
      push_result(STATUS_NOTFOUND, '0, 1'b1);
    end else if (mode == MODE_DELETE) begin
      for (i = pos; i + 1 < key_count; i++) sorted_keys[i] = sorted_keys[i+1];
      key_count--;
      push_result(STATUS_OK, '0, 1'b1);
    end else begin
      push_result(STATUS_OK, key, 1'b1);
    end
  endtask

  // Take the result side first so that a result never meets an expectation
  // pushed at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        n_results++;
        got.status = status_e'(m_axis_tdata_i[STATUS_W-1:0]);
        got.key    = m_axis_tdata_i[STATUS_W +: KEY_W];
        got.occ    = m_axis_tdata_i[STATUS_W+KEY_W +: OCC_W];
        got.last   = m_axis_tlast_i;
        if (got.status <= STATUS_EMPTY) seen[got.status] = 1'b1;
        if (due_results.size() == 0) begin
          note_failure($sformatf("result %0d with nothing due: status %0d key %0d occ %0d last %0b",
                                 n_results, got.status, got.key, got.occ, got.last));
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.key !== want.key ||
              got.occ !== want.occ || got.last !== want.last) begin
            note_failure($sformatf({"result %0d mismatch: expected status %0d key %0d occ %0d ",
                                    "last %0b, got status %0d key %0d occ %0d last %0b"},
                                   n_results, want.status, want.key, want.occ, want.last,
                                   got.status, got.key, got.occ, got.last));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        apply_table_op(mode_e'(s_axis_tuser_i), s_axis_tdata_i);
      n_due = due_results.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, delete, search and list items into the key table with
// random gaps on both sides, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_top;
  import sukt_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned PHASE_LEN    = 35;    // items per stimulus phase
  localparam int unsigned POOL_N       = 24;    // keys reused to hit present entries
  localparam int unsigned HOLD_AT      = 120;   // results taken before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned TAIL_CYCLES  = 40;    // longer than a full list
  localparam int unsigned IDLE_LIMIT   = 2000;  // cycles without any handshake

  // Bias of the operation mix: fill up, churn around the middle, drain
  typedef enum int unsigned {
    PH_FILL,
    PH_CHURN,
    PH_DRAIN
  } phase_e;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [KEY_W-1:0]    s_axis_tdata;
  logic [MODE_W-1:0]   s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                m_axis_tlast;

  int unsigned         fail_count;
  int unsigned         pending_count;
  int unsigned         result_count;
  logic [4:0]          status_seen;
  int unsigned         mode_count [4];
  logic [KEY_W-1:0]    key_pool [POOL_N];
  logic                no_idle = 1'b0;
  int unsigned         quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  sorted_unique_key_table #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  sukt_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count),
    .results_o       (result_count),
    .status_seen_o   (status_seen)
  );

  // Offer one item after a random gap and hold it until the block takes it.
  // With no gap, valid stays high straight into the next item.
  task automatic offer_item(input mode_e mode, input logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= key;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    mode_count[mode]++;
    @(negedge clk_i);
  endtask

  function automatic mode_e pick_mode(input phase_e phase);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (phase)
      PH_FILL: begin
        if (r < 60) return MODE_INSERT;
        if (r < 70) return MODE_DELETE;
        if (r < 90) return MODE_SEARCH;
      end
      PH_CHURN: begin
        if (r < 35) return MODE_INSERT;
        if (r < 60) return MODE_DELETE;
        if (r < 88) return MODE_SEARCH;
      end
      default: begin
        if (r < 15) return MODE_INSERT;
        if (r < 65) return MODE_DELETE;
        if (r < 90) return MODE_SEARCH;
      end
    endcase
    return MODE_LIST;
  endfunction

  // Mostly reuse pooled keys so that duplicates and hits are common
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom();
  endfunction

  initial begin : stimulus
    logic [KEY_W-1:0] fill_keys [16];
    int unsigned      i;
    int unsigned      n;
    int unsigned      phase;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_INSERT;
    for (i = 0; i < 4; i++) mode_count[i] = 0;
    // extremes, neighbours of zero and alternating bit patterns, in no order
    fill_keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h7FFF_FFFE, 32'h8000_0001, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                  32'h0000_0064, 32'hFFFF_FF9C, 32'h1234_5678, 32'hEDCB_A987};
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (i = 4; i < POOL_N; i++) key_pool[i] = $urandom();
    wait (rst_ni);
    @(negedge clk_i);

    // Empty table: delete, search and list each report empty
    offer_item(MODE_LIST,   32'h0000_0000);
    offer_item(MODE_DELETE, 32'h0000_0000);
    offer_item(MODE_SEARCH, 32'h8000_0000);
    // Fill to capacity, the first insert going into the empty table
    for (i = 0; i < CAPACITY; i++) offer_item(MODE_INSERT, fill_keys[i]);
    // Full table: a duplicate still reports duplicate, a fresh key reports full
    offer_item(MODE_INSERT, 32'h0000_0000);
    offer_item(MODE_INSERT, 32'h0000_0007);
    offer_item(MODE_LIST,   32'hFFFF_FFFF);
    offer_item(MODE_SEARCH, 32'h7FFF_FFFF);
    offer_item(MODE_SEARCH, 32'h0000_0007);
    offer_item(MODE_DELETE, 32'h0000_0007);
    offer_item(MODE_DELETE, 32'h8000_0000);
    offer_item(MODE_DELETE, 32'h7FFF_FFFF);
    offer_item(MODE_LIST,   32'h0000_0000);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        phase   = n / PHASE_LEN;
        no_idle = (phase % 5 == 3);
        repeat (4) key_pool[$urandom_range(4, POOL_N - 1)] = $urandom();
      end
      offer_item(pick_mode(phase_e'(phase % 3)), pick_key());
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray result
    wait (pending_count == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d items: %0d insert, %0d delete, %0d search, %0d list; %0d results.",
             mode_count[MODE_INSERT] + mode_count[MODE_DELETE] + mode_count[MODE_SEARCH] +
             mode_count[MODE_LIST], mode_count[MODE_INSERT], mode_count[MODE_DELETE],
             mode_count[MODE_SEARCH], mode_count[MODE_LIST], result_count);
    $display("Status codes seen (empty..ok, high to low): %05b; one %0d-cycle receiver hold-off.",
             status_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result sink: random back-pressure, a stretch with none, and one long
  // hold-off while the sender keeps offering items so the block backs up.
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    taken         = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken == HOLD_AT)
        gap = HOLD_CYCLES;
      else if (taken >= 300 && taken < 380)
        gap = 0;
      else
        gap = $urandom_range(0, 6);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
      taken++;
      @(negedge clk_i);
    end
  end

  // Watchdog: end the run when no handshake has happened for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
rtl/sukt_pkg.sv
rtl/sukt_cell.sv
rtl/sorted_unique_key_table.sv
rtl/sukt_checker.sv
verif/sukt_checker.sv
verif/tb_top.sv
